@@ rtl/core/eil4hp_pkg.sv @@
package eil4hp_pkg;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // byte positions inside the frame
  localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
  localparam logic [7:0] IP6_HDR_BYTES = 8'd40;
  localparam logic [7:0] UDP_HDR_BYTES = 8'd8;
  localparam logic [7:0] TCP_OFFS_BYTE = 8'd12;
  localparam logic [7:0] POS_ETYPE_HI  = 8'd12;
  localparam logic [7:0] POS_ETYPE_LO  = 8'd13;
  localparam logic [7:0] POS_V4_IHL    = 8'd14;
  localparam logic [7:0] POS_V4_LEN_HI = 8'd16;
  localparam logic [7:0] POS_V4_LEN_LO = 8'd17;
  localparam logic [7:0] POS_V4_PROTO  = 8'd23;
  localparam logic [7:0] POS_V6_LEN_HI = 8'd18;
  localparam logic [7:0] POS_V6_LEN_LO = 8'd19;
  localparam logic [7:0] POS_V6_NXT    = 8'd20;

  // shortest frames that still carry the fields in use
  localparam logic [7:0] MIN_V4_SIZE = 8'd24;
  localparam logic [7:0] MIN_V6_SIZE = 8'd21;

  localparam logic       NET_IPV4 = 1'b0;
  localparam logic       NET_IPV6 = 1'b1;

  localparam logic [1:0] XPORT_TCP   = 2'd0;
  localparam logic [1:0] XPORT_UDP   = 2'd1;
  localparam logic [1:0] XPORT_OTHER = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;

  // header fields of one finished frame, as captured by the front end
  typedef struct packed {
    logic [7:0]  size;        // frame size, saturated at 255
    logic [15:0] ether_kind;
    logic [3:0]  ihl;
    logic [15:0] ip_len;
    logic [7:0]  proto;
    logic [3:0]  tcp_words;
    logic        tcp_seen;
  } frame_sum_t;

  typedef struct packed {
    logic        accepted;
    logic        net_kind;
    logic [1:0]  transport_kind;
    logic [7:0]  transport_proto;
    logic [7:0]  payload_offset;
    logic [15:0] payload_length;
  } verdict_t;

endpackage

@@ rtl/core/eil4hp_front.sv @@
module eil4hp_front #(
  parameter int unsigned MaxFrame = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   byte_valid_i,
  output logic                   byte_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  output logic                   sum_valid_o,
  input  logic                   sum_ready_i,
  output eil4hp_pkg::frame_sum_t sum_o
);
  import eil4hp_pkg::*;

  localparam int unsigned PosW = $clog2(MaxFrame);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxFrame - 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     ek_q, ek_d;
  logic [3:0]      ihl_q, ihl_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      proto_q, proto_d;
  logic [3:0]      tcpw_q, tcpw_d;
  logic            seen_q, seen_d;

  logic            take;
  logic            cap;
  logic            is_v4, is_v6, past_eth;
  logic [7:0]      xport_start;
  logic [PosW-1:0] tcp_pos;

  function automatic logic at_pos(logic [PosW-1:0] p, logic [7:0] where);
    return 32'(p) == 32'(where);
  endfunction

  assign byte_ready_o = sum_ready_i;
  assign take         = byte_valid_i && sum_ready_i;
  assign cap          = pos_q != PosMax;

  always_comb begin
    ek_d    = ek_q;
    ihl_d   = ihl_q;
    len_d   = len_q;
    proto_d = proto_q;
    tcpw_d  = tcpw_q;
    seen_d  = seen_q;
    pos_d   = cap ? pos_q + PosW'(1) : pos_q;

    if (cap) begin
      if (at_pos(pos_q, POS_ETYPE_HI)) begin
        ek_d = {data_byte_i, 8'h00};
      end else if (at_pos(pos_q, POS_ETYPE_LO)) begin
        ek_d = ek_q | {8'h00, data_byte_i};
      end
    end

    is_v4    = ek_d == ETH_TYPE_IPV4;
    is_v6    = ek_d == ETH_TYPE_IPV6;
    past_eth = 32'(pos_q) >= 32'(ETH_HDR_BYTES);

    if (cap && past_eth) begin
      if (is_v4) begin
        if (at_pos(pos_q, POS_V4_IHL)) begin
          ihl_d = data_byte_i[3:0];
        end else if (at_pos(pos_q, POS_V4_LEN_HI)) begin
          len_d = {data_byte_i, 8'h00};
        end else if (at_pos(pos_q, POS_V4_LEN_LO)) begin
          len_d = len_q | {8'h00, data_byte_i};
        end else if (at_pos(pos_q, POS_V4_PROTO)) begin
          proto_d = data_byte_i;
        end
      end else if (is_v6) begin
        if (at_pos(pos_q, POS_V6_LEN_HI)) begin
          len_d = {data_byte_i, 8'h00};
        end else if (at_pos(pos_q, POS_V6_LEN_LO)) begin
          len_d = len_q | {8'h00, data_byte_i};
        end else if (at_pos(pos_q, POS_V6_NXT)) begin
          proto_d = data_byte_i;
        end
      end
    end

    xport_start = is_v4 ? ETH_HDR_BYTES + {2'b00, ihl_d, 2'b00}
                        : ETH_HDR_BYTES + IP6_HDR_BYTES;
    tcp_pos     = PosW'(xport_start + TCP_OFFS_BYTE);

    // capture the TCP data offset nibble
    if (cap && (is_v4 || is_v6) && proto_d == PROTO_TCP && pos_q == tcp_pos &&
        32'(pos_q) > 32'(POS_V4_PROTO)) begin
      tcpw_d = data_byte_i[7:4];
      seen_d = 1'b1;
    end
  end

  always_comb begin
    sum_o.size       = (32'(pos_d) > 32'd255) ? 8'hFF : 8'(pos_d);
    sum_o.ether_kind = ek_d;
    sum_o.ihl        = ihl_d;
    sum_o.ip_len     = len_d;
    sum_o.proto      = proto_d;
    sum_o.tcp_words  = tcpw_d;
    sum_o.tcp_seen   = seen_d;
  end

  assign sum_valid_o = take && last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ek_q    <= '0;
      ihl_q   <= '0;
      len_q   <= '0;
      proto_q <= '0;
      tcpw_q  <= '0;
      seen_q  <= 1'b0;
    end else if (take) begin
      if (last_byte_i) begin
        // frame done: start the next one from scratch
        pos_q   <= '0;
        ek_q    <= '0;
        ihl_q   <= '0;
        len_q   <= '0;
        proto_q <= '0;
        tcpw_q  <= '0;
        seen_q  <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        ek_q    <= ek_d;
        ihl_q   <= ihl_d;
        len_q   <= len_d;
        proto_q <= proto_d;
        tcpw_q  <= tcpw_d;
        seen_q  <= seen_d;
      end
    end
  end

endmodule

@@ rtl/core/eil4hp_queue.sv @@
module eil4hp_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  eil4hp_pkg::frame_sum_t push_data_i,
  output logic                   not_full_o,
  input  logic                   pop_i,
  output logic                   not_empty_o,
  output eil4hp_pkg::frame_sum_t head_o
);
  import eil4hp_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  frame_sum_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;
  logic                do_push, do_pop;

  assign not_full_o  = 32'(cnt_q) != QUEUE_DEPTH;
  assign not_empty_o = cnt_q != '0;
  assign head_o      = mem_q[rd_q];
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/core/eil4hp_back.sv @@
module eil4hp_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sum_valid_i,
  output logic                   sum_pop_o,
  input  eil4hp_pkg::frame_sum_t sum_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output eil4hp_pkg::verdict_t   verdict_o
);
  import eil4hp_pkg::*;

  logic        valid_q;
  verdict_t    verdict_q;
  verdict_t    verdict_d;
  logic        load;
  logic        ok;
  logic        is_v4, is_v6;
  logic [7:0]  xport_start;
  logic [7:0]  off;
  logic [15:0] translen;
  logic [15:0] plen;
  logic [1:0]  kind;
  logic [15:0] tcp_bytes;

  assign load      = sum_valid_i && (!valid_q || out_ready_i);
  assign sum_pop_o = load;

  always_comb begin
    is_v4     = sum_i.ether_kind == ETH_TYPE_IPV4;
    is_v6     = sum_i.ether_kind == ETH_TYPE_IPV6;
    tcp_bytes = {10'b0, sum_i.tcp_words, 2'b00};

    priority if (sum_i.size < ETH_HDR_BYTES) begin
      ok = 1'b0;
    end else if (is_v4) begin
      ok = sum_i.size >= MIN_V4_SIZE;
    end else if (is_v6) begin
      ok = sum_i.size >= MIN_V6_SIZE;
    end else begin
      ok = 1'b0;
    end

    xport_start = is_v4 ? ETH_HDR_BYTES + {2'b00, sum_i.ihl, 2'b00}
                        : ETH_HDR_BYTES + IP6_HDR_BYTES;
    translen    = is_v6 ? sum_i.ip_len
                        : sum_i.ip_len - {10'b0, sum_i.ihl, 2'b00};

    priority if (sum_i.proto == PROTO_TCP) begin
      kind = XPORT_TCP;
      off  = xport_start + {2'b00, sum_i.tcp_words, 2'b00};
      plen = translen - tcp_bytes;
      if (!sum_i.tcp_seen) begin
        ok = 1'b0;
      end
    end else if (sum_i.proto == PROTO_UDP) begin
      kind = XPORT_UDP;
      off  = xport_start + UDP_HDR_BYTES;
      plen = translen - {8'h00, UDP_HDR_BYTES};
    end else begin
      kind = XPORT_OTHER;
      off  = xport_start;
      plen = '0;
    end

    if (off > sum_i.size) begin
      ok = 1'b0;
    end

    // a rejected frame reports all fields as zero
    if (ok) begin
      verdict_d.accepted        = 1'b1;
      verdict_d.net_kind        = is_v6 ? NET_IPV6 : NET_IPV4;
      verdict_d.transport_kind  = kind;
      verdict_d.transport_proto = sum_i.proto;
      verdict_d.payload_offset  = off;
      verdict_d.payload_length  = plen;
    end else begin
      verdict_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      verdict_q <= verdict_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign verdict_o   = verdict_q;

endmodule

@@ rtl/core/ethernet_ip_l4_header_parser_core.sv @@
// Ethernet / IPv4 / IPv6 / TCP / UDP header parser.
// Input stream: one frame byte per transfer on s_axis_tdata, starting at the
// destination address, with s_axis_tlast on the final byte of the frame.
// Output stream: one verdict per frame on m_axis_*: accepted flag, protocol
// byte, layer-7 payload offset and unsigned payload length in tdata, network
// and transport kind in tuser. A rejected frame gives an all-zero verdict.
// Throughput: one byte per cycle while the queue has room; frames may follow
// back to back, and one-byte frames still give one verdict per cycle while
// the receiver is ready. The verdict of a frame passes through the two-entry
// queue between capture and verdict and then one register stage to m_axis_*.
// Frame size counts up to MaxFrame - 1; later bytes pass uncaptured.
// Reset clears the capture state, empties the queue and clears the output
// valid flag; the block is ready for bytes as soon as reset is released.
// When the receiver stalls, up to two finished frames wait in the queue and
// one in the output register; s_axis_tready falls only once the queue is full.
module ethernet_ip_l4_header_parser_core #(
  parameter int unsigned MaxFrame = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [8:1] transport_proto, [16:9] payload_offset,
  // [32:17] payload_length, [39:33] zero
  output logic [39:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser   // [0] net_kind, [2:1] transport_kind
);
  import eil4hp_pkg::*;

  logic       sum_push;
  frame_sum_t sum_in;
  logic       q_not_full;
  logic       q_not_empty;
  logic       q_pop;
  frame_sum_t q_head;
  verdict_t   verdict;

  eil4hp_front #(
    .MaxFrame(MaxFrame)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s_axis_tvalid),
    .byte_ready_o(s_axis_tready),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .sum_valid_o (sum_push),
    .sum_ready_i (q_not_full),
    .sum_o       (sum_in)
  );

  eil4hp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (sum_push),
    .push_data_i(sum_in),
    .not_full_o (q_not_full),
    .pop_i      (q_pop),
    .not_empty_o(q_not_empty),
    .head_o     (q_head)
  );

  eil4hp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sum_valid_i(q_not_empty),
    .sum_pop_o  (q_pop),
    .sum_i      (q_head),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .verdict_o  (verdict)
  );

  assign m_axis_tdata = {7'b0, verdict.payload_length, verdict.payload_offset,
                         verdict.transport_proto, verdict.accepted};
  assign m_axis_tuser = {verdict.transport_kind, verdict.net_kind};

endmodule

@@ dv/ethernet_ip_l4_header_parser_core_tb.sv @@
module ethernet_ip_l4_header_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eil4hp_pkg::*;

  localparam int unsigned FRAME_CAP  = 4096;
  localparam int unsigned WORD_BYTES = 4;
  localparam verdict_t    REJECT     = '0;

  // one frame to send: header fields to plant, size, and an optional fixed verdict
  typedef struct {
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [15:0] ip_len;
    logic [7:0]  proto;
    logic [3:0]  tcp_words;
    int unsigned size;
    bit          typed;
    verdict_t    want;
  } frame_spec_t;

  localparam int N_DIRECTED = 22;

  frame_spec_t plan [N_DIRECTED] = '{
    '{ETH_TYPE_IPV4, 4'd5,  16'd40,    PROTO_TCP, 4'd5,  54,   1'b0, REJECT},
    '{ETH_TYPE_IPV4, 4'd5,  16'd28,    PROTO_UDP, 4'd0,  42,   1'b0, REJECT},
    '{ETH_TYPE_IPV4, 4'd5,  16'd28,    PROTO_UDP, 4'd0,  41,   1'b1, REJECT},
    '{ETH_TYPE_IPV4, 4'd0,  16'd10,    8'd1,      4'd0,  24,   1'b1,
      '{1'b1, NET_IPV4, XPORT_OTHER, 8'd1, 8'd14, 16'd0}},
    '{ETH_TYPE_IPV4, 4'd5,  16'd60,    8'd1,      4'd0,  34,   1'b0, REJECT},
    '{ETH_TYPE_IPV6, 4'd0,  16'd20,    PROTO_TCP, 4'd5,  74,   1'b0, REJECT},
    '{ETH_TYPE_IPV6, 4'd0,  16'd8,     PROTO_UDP, 4'd0,  62,   1'b0, REJECT},
    '{ETH_TYPE_IPV6, 4'd0,  16'd4,     8'd58,     4'd0,  54,   1'b0, REJECT},
    '{16'h0806,      4'd5,  16'd46,    PROTO_UDP, 4'd0,  20,   1'b1, REJECT},
    '{16'h0000,      4'd5,  16'd0,     PROTO_UDP, 4'd0,  14,   1'b1, REJECT},
    '{16'hFFFF,      4'd15, 16'hFFFF,  PROTO_TCP, 4'd15, 20,   1'b1, REJECT},
    '{ETH_TYPE_IPV4, 4'd5,  16'd0,     PROTO_UDP, 4'd0,  1,    1'b1, REJECT},
    '{ETH_TYPE_IPV4, 4'd5,  16'd0,     PROTO_UDP, 4'd0,  13,   1'b1, REJECT},
    '{ETH_TYPE_IPV4, 4'd5,  16'd0,     8'd1,      4'd0,  23,   1'b1, REJECT},
    '{ETH_TYPE_IPV6, 4'd0,  16'd0,     8'd59,     4'd0,  20,   1'b1, REJECT},
    '{ETH_TYPE_IPV6, 4'd0,  16'd0,     8'd59,     4'd0,  21,   1'b1, REJECT},
    '{ETH_TYPE_IPV4, 4'd5,  16'd40,    PROTO_TCP, 4'd5,  46,   1'b1, REJECT},
    '{ETH_TYPE_IPV6, 4'd0,  16'd20,    PROTO_TCP, 4'd5,  66,   1'b1, REJECT},
    '{ETH_TYPE_IPV4, 4'd15, 16'd0,     PROTO_TCP, 4'd15, 134,  1'b0, REJECT},
    '{ETH_TYPE_IPV4, 4'd0,  16'hFFFF,  PROTO_TCP, 4'd0,  27,   1'b0, REJECT},
    '{ETH_TYPE_IPV6, 4'd0,  16'hFFFF,  PROTO_UDP, 4'd0,  62,   1'b0, REJECT},
    '{ETH_TYPE_IPV4, 4'd5,  16'hFFFF,  8'hFF,     4'd0,  40,   1'b0, REJECT}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // header capture state of the frame in flight
  int unsigned frame_pos     = 0;
  logic [15:0] eth_type      = '0;
  logic [3:0]  ihl_words     = '0;
  logic [15:0] ip_len_field  = '0;
  logic [7:0]  l4_proto      = '0;
  logic [3:0]  tcp_words     = '0;
  bit          tcp_offs_seen = 1'b0;

  verdict_t    pending_verdicts[$];
  int unsigned verdicts_seen = 0;
  int unsigned errors = 0;
  bit          gaps_on = 1'b1;

  always #5 clk_i = ~clk_i;

  ethernet_ip_l4_header_parser_core #(
    .MaxFrame(FRAME_CAP)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  function automatic int unsigned l4_start(logic [15:0] et, logic [3:0] ihl);
    if (et == ETH_TYPE_IPV4) return ETH_HDR_BYTES + WORD_BYTES * ihl;
    return ETH_HDR_BYTES + IP6_HDR_BYTES;
  endfunction

  // advance the header capture by one byte; on the last byte produce the verdict
  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output bit has_verdict, output verdict_t v);
    int unsigned p;
    int unsigned fsize;
    int unsigned off;
    logic [15:0] l4_len;
    logic [15:0] plen;
    logic [1:0]  kind;
    bit          ok;
    bit          is_v6;
    has_verdict = 1'b0;
    v = REJECT;
    p = frame_pos;
    if (p < FRAME_CAP - 1) begin
      if (p == POS_ETYPE_HI) eth_type = {b, 8'h00};
      else if (p == POS_ETYPE_LO) eth_type = eth_type | {8'h00, b};
      if (eth_type == ETH_TYPE_IPV4 && p >= ETH_HDR_BYTES) begin
        if (p == POS_V4_IHL) ihl_words = b[3:0];
        else if (p == POS_V4_LEN_HI) ip_len_field = {b, 8'h00};
        else if (p == POS_V4_LEN_LO) ip_len_field = ip_len_field | {8'h00, b};
        else if (p == POS_V4_PROTO) l4_proto = b;
      end else if (eth_type == ETH_TYPE_IPV6 && p >= ETH_HDR_BYTES) begin
        if (p == POS_V6_LEN_HI) ip_len_field = {b, 8'h00};
        else if (p == POS_V6_LEN_LO) ip_len_field = ip_len_field | {8'h00, b};
        else if (p == POS_V6_NXT) l4_proto = b;
      end
      if ((eth_type == ETH_TYPE_IPV4 || eth_type == ETH_TYPE_IPV6) &&
          l4_proto == PROTO_TCP && p == l4_start(eth_type, ihl_words) + TCP_OFFS_BYTE &&
          p > POS_V4_PROTO) begin
        tcp_words = b[7:4];
        tcp_offs_seen = 1'b1;
      end
      frame_pos = p + 1;
    end
    if (!last) return;

    fsize = frame_pos;
    is_v6 = (eth_type == ETH_TYPE_IPV6);
    if (fsize < ETH_HDR_BYTES) ok = 1'b0;
    else if (eth_type == ETH_TYPE_IPV4) ok = (fsize >= MIN_V4_SIZE);
    else if (is_v6) ok = (fsize >= MIN_V6_SIZE);
    else ok = 1'b0;

    off  = 0;
    kind = XPORT_OTHER;
    plen = '0;
    if (ok) begin
      off = l4_start(eth_type, ihl_words);
      l4_len = is_v6 ? ip_len_field : ip_len_field - 16'(WORD_BYTES * ihl_words);
      if (l4_proto == PROTO_TCP) begin
        kind = XPORT_TCP;
        if (!tcp_offs_seen) ok = 1'b0;
        off += WORD_BYTES * tcp_words;
        plen = l4_len - 16'(WORD_BYTES * tcp_words);
      end else if (l4_proto == PROTO_UDP) begin
        kind = XPORT_UDP;
        off += UDP_HDR_BYTES;
        plen = l4_len - 16'(UDP_HDR_BYTES);
      end
      if (off > fsize) ok = 1'b0;
    end
    if (ok) begin
      v = '{accepted: 1'b1, net_kind: is_v6 ? NET_IPV6 : NET_IPV4, transport_kind: kind,
            transport_proto: l4_proto, payload_offset: 8'(off), payload_length: plen};
    end
    has_verdict   = 1'b1;
    frame_pos     = 0;
    eth_type      = '0;
    ihl_words     = '0;
    ip_len_field  = '0;
    l4_proto      = '0;
    tcp_words     = '0;
    tcp_offs_seen = 1'b0;
  endtask

  function automatic void plant(ref logic [7:0] fb[$], input int unsigned pos,
                                input logic [7:0] val);
    if (pos < fb.size()) fb[pos] = val;
  endfunction

  // random bytes with the header fields of the spec written in place
  function automatic void build_frame(input frame_spec_t f, ref logic [7:0] fb[$]);
    fb.delete();
    repeat (f.size) fb.push_back(8'($urandom));
    plant(fb, POS_ETYPE_HI, f.etype[15:8]);
    plant(fb, POS_ETYPE_LO, f.etype[7:0]);
    if (f.etype == ETH_TYPE_IPV4) begin
      plant(fb, POS_V4_IHL, {4'($urandom), f.ihl});
      plant(fb, POS_V4_LEN_HI, f.ip_len[15:8]);
      plant(fb, POS_V4_LEN_LO, f.ip_len[7:0]);
      plant(fb, POS_V4_PROTO, f.proto);
    end else if (f.etype == ETH_TYPE_IPV6) begin
      plant(fb, POS_V6_LEN_HI, f.ip_len[15:8]);
      plant(fb, POS_V6_LEN_LO, f.ip_len[7:0]);
      plant(fb, POS_V6_NXT, f.proto);
    end
    if (f.proto == PROTO_TCP)
      plant(fb, l4_start(f.etype, f.ihl) + TCP_OFFS_BYTE, {f.tcp_words, 4'($urandom)});
  endfunction

  // mostly well-formed frames, some cut short, some noise
  function automatic frame_spec_t random_frame();
    frame_spec_t f;
    int unsigned t;
    int unsigned need;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    f.typed = 1'b0;
    f.want  = REJECT;
    f.etype = $urandom_range(0, 1) ? ETH_TYPE_IPV4 : ETH_TYPE_IPV6;
    f.ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
    f.tcp_words = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
    if (sel < 4) f.proto = PROTO_TCP;
    else if (sel < 8) f.proto = PROTO_UDP;
    else f.proto = 8'($urandom);
    t = l4_start(f.etype, f.ihl);
    if (f.proto == PROTO_TCP) begin
      need = t + WORD_BYTES * f.tcp_words;
      if (need < t + TCP_OFFS_BYTE + 1) need = t + TCP_OFFS_BYTE + 1;
    end else if (f.proto == PROTO_UDP) begin
      need = t + UDP_HDR_BYTES;
    end else begin
      need = t;
    end
    if (f.etype == ETH_TYPE_IPV4 && need < MIN_V4_SIZE) need = MIN_V4_SIZE;
    f.size = need + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8));
    if ($urandom_range(0, 4) == 0) f.ip_len = 16'($urandom);
    else if (f.etype == ETH_TYPE_IPV4) f.ip_len = 16'(f.size - ETH_HDR_BYTES);
    else f.ip_len = 16'(f.size - ETH_HDR_BYTES - IP6_HDR_BYTES);
    if (pick >= 85) begin
      f.etype = 16'($urandom);
      f.proto = 8'($urandom);
      f.size  = $urandom_range(1, 80);
    end else if (pick >= 70) begin
      f.size = $urandom_range(1, need - 1);
    end
    return f;
  endfunction

  task automatic send_frame(input frame_spec_t f);
    logic [7:0] fb[$];
    bit         has_verdict;
    verdict_t   v;
    logic       last;
    build_frame(f, fb);
    foreach (fb[i]) begin
      if (gaps_on && $urandom_range(0, 9) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      last = (i == fb.size() - 1);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= fb[i];
      s_axis_tlast  <= last;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      parse_byte(fb[i], last, has_verdict, v);
      if (has_verdict) pending_verdicts.push_back(f.typed ? f.want : v);
    end
  endtask

  // hold the sender until every verdict is out
  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string msg);
    if (errors < 100) $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("verdict %0d %s: got %0h, expected %0h",
                                verdicts_seen, name, got, want));
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      report_mismatch($sformatf("verdict %0d arrived with none pending (tdata %0h)",
                                verdicts_seen, m_axis_tdata));
    end else begin
      want = pending_verdicts.pop_front();
      check_field("accepted", 32'(m_axis_tdata[0]), 32'(want.accepted));
      check_field("net_kind", 32'(m_axis_tuser[0]), 32'(want.net_kind));
      check_field("transport_kind", 32'(m_axis_tuser[2:1]), 32'(want.transport_kind));
      check_field("transport_proto", 32'(m_axis_tdata[8:1]), 32'(want.transport_proto));
      check_field("payload_offset", 32'(m_axis_tdata[16:9]), 32'(want.payload_offset));
      check_field("payload_length", 32'(m_axis_tdata[32:17]), 32'(want.payload_length));
      check_field("padding", 32'(m_axis_tdata[39:33]), '0);
    end
    verdicts_seen++;
  endtask

  // verdict side: check each transfer, stall in bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_verdict();
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    frame_spec_t f;
    int unsigned rand_frames;
    int unsigned sent_bytes;
    rand_frames = 0;
    sent_bytes  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      send_frame(plan[i]);
      sent_bytes += plan[i].size;
    end
    drain_verdicts();

    while (rand_frames < 4 || sent_bytes < 1100) begin
      f = random_frame();
      // quiet tail: no gaps or stalls near the end
      gaps_on = (sent_bytes < 1000) && ($urandom_range(0, 3) != 0);
      if (sent_bytes < 1000 && $urandom_range(0, 3) == 0) drain_verdicts();
      send_frame(f);
      rand_frames++;
      sent_bytes += f.size;
    end
    gaps_on = 1'b0;
    s_axis_tvalid <= 1'b0;

    for (int n = 0; n < 2000 && pending_verdicts.size() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
